/* hw/rtl/thp_sensor_compensation_macros.svh */
// ----------------------------------------------------------------------------
// thp sensor compensation assertion macros
// shared assertion forms for the compensation block checkers
// ----------------------------------------------------------------------------
`ifndef THP_SENSOR_COMPENSATION_MACROS_SVH
`define THP_SENSOR_COMPENSATION_MACROS_SVH

// same-cycle implication, off during reset
`define THP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("thp assertion failed");

// next-cycle implication, off during reset
`define THP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("thp assertion failed");

`endif

/* hw/rtl/thp_pkg.sv */
// ----------------------------------------------------------------------------
// thp_pkg
// shared types, constants and helpers of the sensor compensation pipeline
// ----------------------------------------------------------------------------
package thp_pkg;

  localparam int unsigned DIV_W  = 64;
  localparam int unsigned NPRE   = 13;
  localparam int unsigned NPOST  = 5;

  localparam logic [31:0] P_OFS    = 32'd128000;
  localparam logic [63:0] ADC_FULL = 64'd1048576;
  localparam logic [63:0] P_SCALE  = 64'd3125;
  localparam logic [31:0] H_OFS    = 32'd76800;
  localparam logic [31:0] H_RND    = 32'd16384;
  localparam logic [31:0] X2_OFS   = 32'd2097152;
  localparam logic [31:0] X3_RND   = 32'd8192;
  localparam logic [31:0] X_OFS    = 32'd32768;
  localparam logic [31:0] HUM_MAX  = 32'd419430400;

  localparam logic [2:0] REG_TEMP_CAL   = 3'd0;
  localparam logic [2:0] REG_PRESS_LOW  = 3'd1;
  localparam logic [2:0] REG_PRESS_MID  = 3'd2;
  localparam logic [2:0] REG_PRESS_HIGH = 3'd3;
  localparam logic [2:0] REG_HUM_A      = 3'd4;
  localparam logic [2:0] REG_HUM_B      = 3'd5;

  typedef struct packed {
    logic [31:0] temp;
    logic [16:0] hum;
    logic        inv;
  } side_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] tv1;
    logic [31:0] bb;
    logic [31:0] tv2;
    logic [31:0] tfine;
    logic [31:0] vh;
    logic [31:0] temp;
    logic [31:0] ha;
    logic [31:0] hb;
    logic [31:0] hc;
    logic [31:0] x1;
    logic [31:0] hd;
    logic [31:0] x2;
    logic [31:0] hx;
    logic [31:0] x3;
    logic [31:0] hv;
    logic [31:0] ss;
    logic [31:0] hum32;
    logic [32:0] v1p;
    logic [63:0] sq;
    logic [63:0] m5;
    logic [63:0] m2;
    logic [63:0] v2a;
    logic [63:0] v1a;
    logic [63:0] v2;
    logic [63:0] v1b;
    logic [63:0] vm;
    logic [63:0] pn;
    logic [63:0] pnum;
    logic [63:0] dv;
    logic [19:0] rp;
    logic [15:0] rh;
    side_t       side;
  } pl_t;

  typedef struct packed {
    logic [63:0] p;
    logic [63:0] pq;
    logic [63:0] w2;
    logic [63:0] a1;
    logic [63:0] ll;
    logic [31:0] lh;
    logic [31:0] hl;
    logic [63:0] w1;
    logic [63:0] r;
    logic [31:0] press;
    side_t       side;
  } pt_t;

  function automatic logic [31:0] asr32(logic [31:0] x, int unsigned s);
    return 32'($signed(x) >>> s);
  endfunction

  function automatic logic [63:0] asr64(logic [63:0] x, int unsigned s);
    return 64'($signed(x) >>> s);
  endfunction

  function automatic logic [63:0] mul33(logic signed [32:0] x, logic signed [32:0] y);
    logic signed [65:0] r;
    r = x * y;
    return r[63:0];
  endfunction

  function automatic logic [63:0] mul64(logic signed [63:0] x, logic signed [16:0] y);
    logic signed [63:0] r;
    r = x * y;
    return r;
  endfunction

endpackage

/* hw/rtl/thp_in_if.sv */
// ----------------------------------------------------------------------------
// thp_in_if
// request channel carrying one raw sample triple
// ----------------------------------------------------------------------------
interface thp_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temp;
  logic [19:0] raw_press;
  logic [15:0] raw_hum;

  modport source (output valid, output raw_temp, output raw_press, output raw_hum,
                  input ready);
  modport sink (input valid, input raw_temp, input raw_press, input raw_hum,
                output ready);
endinterface

/* hw/rtl/thp_out_if.sv */
// ----------------------------------------------------------------------------
// thp_out_if
// result channel carrying compensated temperature, pressure and humidity
// ----------------------------------------------------------------------------
interface thp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] temp_centi;
  logic [31:0] press_q24_8;
  logic [16:0] hum_q22_10;
  logic        press_invalid;

  modport source (output valid, output temp_centi, output press_q24_8,
                  output hum_q22_10, output press_invalid, input ready);
  modport sink (input valid, input temp_centi, input press_q24_8,
                input hum_q22_10, input press_invalid, output ready);
endinterface

/* hw/rtl/thp_div.sv */
// ----------------------------------------------------------------------------
// thp_div
// pipelined signed 64-bit divider, one quotient bit per stage, truncating
// ----------------------------------------------------------------------------
module thp_div import thp_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [DIV_W-1:0] num,
  input  logic [DIV_W-1:0] den,
  input  side_t            in_side,
  output logic             out_valid,
  output logic [DIV_W-1:0] quo,
  output side_t            out_side
);

  logic             v_r    [DIV_W+1];
  logic [DIV_W-1:0] rem_r  [DIV_W+1];
  logic [DIV_W-1:0] nq_r   [DIV_W+1];
  logic [DIV_W-1:0] d_r    [DIV_W+1];
  logic             neg_r  [DIV_W+1];
  side_t            side_r [DIV_W+1];

  logic [DIV_W-1:0] rem_nxt [DIV_W];
  logic [DIV_W-1:0] nq_nxt  [DIV_W];
  logic [DIV_W:0]   t_c     [DIV_W];

  logic             qv_r;
  logic [DIV_W-1:0] q_r;
  side_t            qside_r;

  always_comb begin
    for (int i = 0; i < DIV_W; i++) begin
      t_c[i] = {rem_r[i], nq_r[i][DIV_W-1]};
      if (t_c[i] >= {1'b0, d_r[i]}) begin
        rem_nxt[i] = DIV_W'(t_c[i] - {1'b0, d_r[i]});
        nq_nxt[i]  = {nq_r[i][DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt[i] = t_c[i][DIV_W-1:0];
        nq_nxt[i]  = {nq_r[i][DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= DIV_W; i++) begin
        v_r[i] <= 1'b0;
      end
      qv_r <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
      for (int i = 0; i < DIV_W; i++) begin
        v_r[i+1] <= v_r[i];
      end
      qv_r <= v_r[DIV_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      nq_r[0]   <= num[DIV_W-1] ? DIV_W'(0) - num : num;
      d_r[0]    <= den[DIV_W-1] ? DIV_W'(0) - den : den;
      neg_r[0]  <= num[DIV_W-1] ^ den[DIV_W-1];
      side_r[0] <= in_side;
      for (int i = 0; i < DIV_W; i++) begin
        rem_r[i+1]  <= rem_nxt[i];
        nq_r[i+1]   <= nq_nxt[i];
        d_r[i+1]    <= d_r[i];
        neg_r[i+1]  <= neg_r[i];
        side_r[i+1] <= side_r[i];
      end
      q_r     <= neg_r[DIV_W] ? DIV_W'(0) - nq_r[DIV_W] : nq_r[DIV_W];
      qside_r <= side_r[DIV_W];
    end
  end

  assign out_valid = qv_r;
  assign quo       = q_r;
  assign out_side  = qside_r;

endmodule

/* hw/rtl/thp_sensor_compensation.sv */
// ----------------------------------------------------------------------------
// thp_sensor_compensation
// integer temperature, pressure and humidity compensation pipeline
// ----------------------------------------------------------------------------
// Fully pipelined: one sample triple is taken every cycle unless a result is
// stalled; each result passes 13 front stages of temperature, humidity and
// pressure products, 66 stages of the bit-per-stage pressure divider and 5
// back stages of pressure correction and saturation. A stalled result holds
// the whole pipeline. Calibration registers sit at byte address 8*i on the
// APB port, to be written only while the pipeline is empty (not enforced).
module thp_sensor_compensation import thp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  thp_in_if.sink        in_ch,
  thp_out_if.source     out_ch,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);

  logic [47:0] temp_cal_r;
  logic [47:0] press_low_r;
  logic [47:0] press_mid_r;
  logic [47:0] press_high_r;
  logic [31:0] hum_a_r;
  logic [31:0] hum_b_r;

  logic        en;
  logic        pre_v_r  [NPRE];
  pl_t         st_r     [NPRE];
  pl_t         st_nxt   [NPRE];
  logic        div_v;
  logic [63:0] div_q;
  side_t       div_side;
  logic        post_v_r [NPOST];
  pt_t         pt_r     [NPOST];
  pt_t         pt_nxt   [NPOST];

  logic [31:0] t1, t2, t3;
  logic [31:0] h1, h2, h3, h4, h5, h6;
  logic signed [16:0] p1_s, p2_s, p3_s, p4_s, p5_s, p6_s, p7_s, p8_s, p9_s;
  logic [31:0] s_c;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r   <= '0;
      press_low_r  <= '0;
      press_mid_r  <= '0;
      press_high_r <= '0;
      hum_a_r      <= '0;
      hum_b_r      <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[5:3])
        REG_TEMP_CAL:   temp_cal_r   <= pwdata[47:0];
        REG_PRESS_LOW:  press_low_r  <= pwdata[47:0];
        REG_PRESS_MID:  press_mid_r  <= pwdata[47:0];
        REG_PRESS_HIGH: press_high_r <= pwdata[47:0];
        REG_HUM_A:      hum_a_r      <= pwdata[31:0];
        REG_HUM_B:      hum_b_r      <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[5:3])
      REG_TEMP_CAL:   prdata = {16'd0, temp_cal_r};
      REG_PRESS_LOW:  prdata = {16'd0, press_low_r};
      REG_PRESS_MID:  prdata = {16'd0, press_mid_r};
      REG_PRESS_HIGH: prdata = {16'd0, press_high_r};
      REG_HUM_A:      prdata = {32'd0, hum_a_r};
      REG_HUM_B:      prdata = {32'd0, hum_b_r};
      default:        prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // coefficient fields
  assign t1   = {16'd0, temp_cal_r[15:0]};
  assign t2   = {{16{temp_cal_r[31]}}, temp_cal_r[31:16]};
  assign t3   = {{16{temp_cal_r[47]}}, temp_cal_r[47:32]};
  assign p1_s = {1'b0, press_low_r[15:0]};
  assign p2_s = {press_low_r[31], press_low_r[31:16]};
  assign p3_s = {press_low_r[47], press_low_r[47:32]};
  assign p4_s = {press_mid_r[15], press_mid_r[15:0]};
  assign p5_s = {press_mid_r[31], press_mid_r[31:16]};
  assign p6_s = {press_mid_r[47], press_mid_r[47:32]};
  assign p7_s = {press_high_r[15], press_high_r[15:0]};
  assign p8_s = {press_high_r[31], press_high_r[31:16]};
  assign p9_s = {press_high_r[47], press_high_r[47:32]};
  assign h1   = {24'd0, hum_a_r[7:0]};
  assign h2   = {{16{hum_a_r[23]}}, hum_a_r[23:8]};
  assign h3   = {24'd0, hum_a_r[31:24]};
  assign h4   = {{20{hum_b_r[11]}}, hum_b_r[11:0]};
  assign h5   = {{20{hum_b_r[23]}}, hum_b_r[23:12]};
  assign h6   = {{24{hum_b_r[31]}}, hum_b_r[31:24]};

  assign en          = !post_v_r[NPOST-1] || out_ch.ready;
  assign in_ch.ready = en;

  // front stages
  always_comb begin
    st_nxt[0] = st_r[0];
    for (int k = 1; k < NPRE; k++) begin
      st_nxt[k] = st_r[k-1];
    end
    s_c = asr32(st_r[9].hv, 15);

    st_nxt[0].a  = 32'(in_ch.raw_temp >> 3) - (t1 << 1);
    st_nxt[0].b  = 32'(in_ch.raw_temp >> 4) - t1;
    st_nxt[0].rp = in_ch.raw_press;
    st_nxt[0].rh = in_ch.raw_hum;

    st_nxt[1].tv1 = asr32(st_r[0].a * t2, 11);
    st_nxt[1].bb  = st_r[0].b * st_r[0].b;

    st_nxt[2].tv2 = asr32(asr32(st_r[1].bb, 12) * t3, 14);

    st_nxt[3].tfine = st_r[2].tv1 + st_r[2].tv2;
    st_nxt[3].v1p   = {st_nxt[3].tfine[31], st_nxt[3].tfine} - {1'b0, P_OFS};
    st_nxt[3].vh    = st_nxt[3].tfine - H_OFS;

    st_nxt[4].temp = asr32(st_r[3].tfine * 32'd5 + 32'd128, 8);
    st_nxt[4].sq   = mul33(st_r[3].v1p, st_r[3].v1p);
    st_nxt[4].m5   = mul33(st_r[3].v1p, {{16{p5_s[16]}}, p5_s});
    st_nxt[4].m2   = mul33(st_r[3].v1p, {{16{p2_s[16]}}, p2_s});
    st_nxt[4].ha   = h5 * st_r[3].vh;
    st_nxt[4].hb   = st_r[3].vh * h6;
    st_nxt[4].hc   = st_r[3].vh * h3;

    st_nxt[5].v2a = mul64(st_r[4].sq, p6_s);
    st_nxt[5].v1a = mul64(st_r[4].sq, p3_s);
    st_nxt[5].x1  = asr32((32'(st_r[4].rh) << 14) - (h4 << 20) - st_r[4].ha + H_RND, 15);
    st_nxt[5].hd  = asr32(st_r[4].hb, 10) * (asr32(st_r[4].hc, 11) + X_OFS);

    st_nxt[6].v2  = st_r[5].v2a + (st_r[5].m5 << 17) + ({{47{p4_s[16]}}, p4_s} << 35);
    st_nxt[6].v1b = asr64(st_r[5].v1a, 8) + (st_r[5].m2 << 12);
    st_nxt[6].x2  = asr32(st_r[5].hd, 10) + X2_OFS;

    st_nxt[7].hx = st_r[6].x2 * h2;
    st_nxt[7].vm = mul64((64'd1 << 47) + st_r[6].v1b, p1_s);
    st_nxt[7].pn = ((ADC_FULL - 64'(st_r[6].rp)) << 31) - st_r[6].v2;

    st_nxt[8].x3   = asr32(st_r[7].hx + X3_RND, 14);
    st_nxt[8].dv   = asr64(st_r[7].vm, 33);
    st_nxt[8].pnum = st_r[7].pn * P_SCALE;

    st_nxt[9].hv = st_r[8].x1 * st_r[8].x3;

    st_nxt[10].ss = s_c * s_c;

    st_nxt[11].hum32 = st_r[10].hv - asr32(asr32(st_r[10].ss, 7) * h1, 4);

    st_nxt[12].side.temp = st_r[11].temp;
    st_nxt[12].side.inv  = (st_r[11].dv == 64'd0);
    if (st_r[11].hum32[31]) begin
      st_nxt[12].side.hum = '0;
    end else if (st_r[11].hum32 > HUM_MAX) begin
      st_nxt[12].side.hum = HUM_MAX[28:12];
    end else begin
      st_nxt[12].side.hum = st_r[11].hum32[28:12];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NPRE; k++) begin
        pre_v_r[k] <= 1'b0;
      end
    end else if (en) begin
      pre_v_r[0] <= in_ch.valid;
      for (int k = 1; k < NPRE; k++) begin
        pre_v_r[k] <= pre_v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NPRE; k++) begin
        st_r[k] <= st_nxt[k];
      end
    end
  end

  thp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pre_v_r[NPRE-1]),
    .num       (st_r[NPRE-1].pnum),
    .den       (st_r[NPRE-1].dv),
    .in_side   (st_r[NPRE-1].side),
    .out_valid (div_v),
    .quo       (div_q),
    .out_side  (div_side)
  );

  // back stages
  always_comb begin
    pt_nxt[0] = pt_r[0];
    for (int k = 1; k < NPOST; k++) begin
      pt_nxt[k] = pt_r[k-1];
    end

    pt_nxt[0].p    = div_q;
    pt_nxt[0].pq   = asr64(div_q, 13);
    pt_nxt[0].w2   = asr64(mul64(div_q, p8_s), 19);
    pt_nxt[0].a1   = mul64(asr64(div_q, 13), p9_s);
    pt_nxt[0].side = div_side;

    pt_nxt[1].ll = 64'(pt_r[0].a1[31:0]) * 64'(pt_r[0].pq[31:0]);
    pt_nxt[1].lh = pt_r[0].a1[31:0] * pt_r[0].pq[63:32];
    pt_nxt[1].hl = pt_r[0].a1[63:32] * pt_r[0].pq[31:0];

    pt_nxt[2].w1 = asr64(pt_r[1].ll + {pt_r[1].lh + pt_r[1].hl, 32'd0}, 25);

    pt_nxt[3].r = asr64(pt_r[2].p + pt_r[2].w1 + pt_r[2].w2, 8)
                  + ({{47{p7_s[16]}}, p7_s} << 4);

    if (pt_r[3].side.inv || pt_r[3].r[63]) begin
      pt_nxt[4].press = '0;
    end else if (|pt_r[3].r[62:32]) begin
      pt_nxt[4].press = '1;
    end else begin
      pt_nxt[4].press = pt_r[3].r[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NPOST; k++) begin
        post_v_r[k] <= 1'b0;
      end
    end else if (en) begin
      post_v_r[0] <= div_v;
      for (int k = 1; k < NPOST; k++) begin
        post_v_r[k] <= post_v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NPOST; k++) begin
        pt_r[k] <= pt_nxt[k];
      end
    end
  end

  assign out_ch.valid         = post_v_r[NPOST-1];
  assign out_ch.temp_centi    = pt_r[NPOST-1].side.temp;
  assign out_ch.press_q24_8   = pt_r[NPOST-1].press;
  assign out_ch.hum_q22_10    = pt_r[NPOST-1].side.hum;
  assign out_ch.press_invalid = pt_r[NPOST-1].side.inv;

endmodule

/* hw/rtl/thp_sensor_compensation_chk.sv */
// ----------------------------------------------------------------------------
// thp_sensor_compensation_chk
// port-level checks of the compensation pipeline, bound to the top level
// ----------------------------------------------------------------------------
`include "thp_sensor_compensation_macros.svh"

module thp_sensor_compensation_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] temp_centi,
  input logic [31:0] press_q24_8,
  input logic [16:0] hum_q22_10,
  input logic        press_invalid
);

  // a held result freezes the whole pipeline
  `THP_ASSERT_IMPL(a_stall_blocks_in, out_valid && !out_ready, !in_ready)
  `THP_ASSERT_IMPL(a_invalid_zero, out_valid && press_invalid, press_q24_8 == 32'd0)
  `THP_ASSERT_IMPL(a_hum_range, out_valid, hum_q22_10 <= 17'd102400)
  `THP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(temp_centi) && $stable(press_q24_8))

endmodule

bind thp_sensor_compensation thp_sensor_compensation_chk u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .temp_centi    (out_ch.temp_centi),
  .press_q24_8   (out_ch.press_q24_8),
  .hum_q22_10    (out_ch.hum_q22_10),
  .press_invalid (out_ch.press_invalid)
);
